FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the watchdog timer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge, ignored while reset is high.
`define WDT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked on every rising clock edge, reset included.
`define WDT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WDT_ASSERT(label, clk, rst, prop, msg)
`define WDT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/wdt_pkg.sv
// ---------------------------------------------------------------------------
// Watchdog timer package
// Operation and status codes, reset values and item types shared by the
// watchdog timer modules.
// ---------------------------------------------------------------------------
package wdt_pkg;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_KICK = 2'd2,
    OP_TICK = 2'd3
  } wdt_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATA = 2'd1,
    ST_BAD_REQ  = 2'd2
  } wdt_status_t;

  // Timer use codes that own an expiry flag.
  localparam logic [2:0] USE_FRB2 = 3'd1;
  localparam logic [2:0] USE_OEM  = 3'd5;

  localparam logic [2:0] PRETIMER_NONE = 3'd0;
  localparam logic [2:0] EXP_NONE      = 3'd0;

  // Values after reset.
  localparam logic        RST_LOG_ON        = 1'b1;
  localparam logic [2:0]  RST_USE_CODE      = USE_OEM;
  localparam logic [1:0]  RST_ACTION_CODE   = 2'd0;
  localparam logic [2:0]  RST_PRETIMER_CODE = 3'd4;
  localparam logic [31:0] RST_PRETIMEOUT    = 32'd1000;
  localparam logic [31:0] RST_RELOAD        = 32'd2000;

  typedef struct packed {
    wdt_op_t     op;
    logic        log_enable;
    logic [2:0]  timer_use;
    logic [1:0]  timer_action;
    logic [2:0]  pretimer_mode;
    logic [31:0] pretimeout_interval;
    logic [31:0] initial_count;
    logic [4:0]  clear_flags;
    logic        start_running;
  } wdt_item_t;

  typedef struct packed {
    logic [31:0] reload_state;
    logic [31:0] pretimeout_state;
    logic [2:0]  pretimer_state;
    logic [1:0]  action_state;
    logic [2:0]  use_state;
    logic        log_state;
    logic [2:0]  expiry_event;
    logic        pretimer_event;
    logic [4:0]  expiry_flags;
    logic [31:0] present_count;
    logic        running;
    wdt_status_t status;
  } wdt_result_t;

  // Expiry flag owned by a timer use; uses without a flag give zero.
  function automatic logic [4:0] use_flag(input logic [2:0] use_code);
    logic [4:0] flag;
    flag = 5'd0;
    if (use_code >= USE_FRB2 && use_code <= USE_OEM) begin
      flag = 5'b00001 << (use_code - USE_FRB2);
    end
    return flag;
  endfunction

endpackage

FILE: design/wdt_core.sv
// ---------------------------------------------------------------------------
// Watchdog timer core
// Timer state registers and the single-pass update for one operation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wdt_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  wdt_pkg::wdt_item_t  item,
  output wdt_pkg::wdt_result_t result
);
  import wdt_pkg::*;

  logic        run_flag,         run_flag_next;
  logic [31:0] count_now,        count_now_next;
  logic [4:0]  sticky_flags,     sticky_flags_next;
  logic        log_on,           log_on_next;
  logic [2:0]  use_code,         use_code_next;
  logic [1:0]  action_code,      action_code_next;
  logic [2:0]  pretimer_code,    pretimer_code_next;
  logic [31:0] pretimeout_value, pretimeout_value_next;
  logic [31:0] reload_value,     reload_value_next;

  wdt_status_t status;
  logic        pre_ev;
  logic [2:0]  exp_ev;
  logic        eval_en;
  logic [31:0] eval_cnt;
  logic        armed;

  assign armed = (pretimer_code != PRETIMER_NONE);

  always_comb begin
    run_flag_next         = run_flag;
    count_now_next        = count_now;
    sticky_flags_next     = sticky_flags;
    log_on_next           = log_on;
    use_code_next         = use_code;
    action_code_next      = action_code;
    pretimer_code_next    = pretimer_code;
    pretimeout_value_next = pretimeout_value;
    reload_value_next     = reload_value;
    status                = ST_OK;
    pre_ev                = 1'b0;
    exp_ev                = EXP_NONE;
    eval_en               = 1'b0;
    eval_cnt              = count_now;

    case (item.op)
      OP_SET: begin
        if (item.pretimeout_interval > item.initial_count) begin
          status = ST_BAD_DATA;
        end else begin
          log_on_next           = item.log_enable;
          use_code_next         = item.timer_use;
          action_code_next      = item.timer_action;
          pretimer_code_next    = item.pretimer_mode;
          pretimeout_value_next = item.pretimeout_interval;
          reload_value_next     = item.initial_count;
          sticky_flags_next     = sticky_flags & ~item.clear_flags;
          if (!item.start_running) begin
            run_flag_next = 1'b0;
          end else begin
            count_now_next = item.initial_count;
          end
        end
      end
      OP_KICK: begin
        if (run_flag && armed && (count_now < pretimeout_value)) begin
          status = ST_BAD_REQ;
        end else begin
          run_flag_next  = 1'b1;
          count_now_next = reload_value;
          eval_en        = (reload_value == 32'd0);
          eval_cnt       = 32'd0;
        end
      end
      OP_TICK: begin
        if (run_flag) begin
          count_now_next = (count_now != 32'd0) ? count_now - 32'd1 : 32'd0;
          eval_en        = 1'b1;
          eval_cnt       = count_now_next;
        end
      end
      default: begin
      end
    endcase

    // Compare against the pretimeout and expire at zero.
    if (eval_en) begin
      if (armed && (eval_cnt == pretimeout_value) && log_on) begin
        pre_ev = 1'b1;
      end
      if (eval_cnt == 32'd0) begin
        sticky_flags_next = sticky_flags_next | use_flag(use_code);
        run_flag_next     = 1'b0;
        if (log_on) begin
          exp_ev = 3'(action_code) + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag         <= 1'b0;
      count_now        <= 32'd0;
      sticky_flags     <= 5'd0;
      log_on           <= RST_LOG_ON;
      use_code         <= RST_USE_CODE;
      action_code      <= RST_ACTION_CODE;
      pretimer_code    <= RST_PRETIMER_CODE;
      pretimeout_value <= RST_PRETIMEOUT;
      reload_value     <= RST_RELOAD;
    end else if (fire) begin
      run_flag         <= run_flag_next;
      count_now        <= count_now_next;
      sticky_flags     <= sticky_flags_next;
      log_on           <= log_on_next;
      use_code         <= use_code_next;
      action_code      <= action_code_next;
      pretimer_code    <= pretimer_code_next;
      pretimeout_value <= pretimeout_value_next;
      reload_value     <= reload_value_next;
    end
  end

  always_comb begin
    result.status           = status;
    result.running          = run_flag_next;
    result.present_count    = count_now_next;
    result.expiry_flags     = sticky_flags_next;
    result.pretimer_event   = pre_ev;
    result.expiry_event     = exp_ev;
    result.log_state        = log_on_next;
    result.use_state        = use_code_next;
    result.action_state     = action_code_next;
    result.pretimer_state   = pretimer_code_next;
    result.pretimeout_state = pretimeout_value_next;
    result.reload_state     = reload_value_next;
  end

  `WDT_ASSERT(a_expiry_stops, clk, rst,
    fire && (result.expiry_event != EXP_NONE) |=> !run_flag, "expiry left timer running")
  `WDT_ASSERT(a_tick_no_wrap, clk, rst,
    fire && (item.op == OP_TICK) |=> count_now <= $past(count_now), "tick raised the count")
  `WDT_ASSERT(a_reject_holds, clk, rst,
    fire && (result.status != ST_OK) |=> $stable(count_now) && $stable(run_flag),
    "rejected operation changed the timer")

endmodule

FILE: design/watchdog_timer_with_pretimeout.sv
// ---------------------------------------------------------------------------
// Watchdog timer with pretimeout
// Stream-driven watchdog: get, set, kick and millisecond tick operations.
// ---------------------------------------------------------------------------
// Each operation enters on the slave stream and produces exactly one result
// transfer on the master stream. The block sustains one transfer per clock
// while the master side keeps tready high: an operation sits in the input
// register while the core computes the new timer state, and both the state
// and the result register load on the same edge, so the next operation
// already sees the updated state. Each result passes through the input
// register and then the result register before its transfer. The
// result register lets a new transfer be taken while a finished result is
// still waiting; backpressure on the master side propagates back through
// tready. The watchdog number register is written through its own channel,
// which is always ready; it is kept for the event sink and does not change
// any result field.
`include "assert_macros.svh"

module watchdog_timer_with_pretimeout (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser,
  // tdata: log_enable[0], timer_use[3:1], timer_action[5:4],
  // pretimer_mode[8:6], pretimeout_interval[40:9], initial_count[72:41],
  // clear_flags[77:73], start_running[78], zero pad[79]
  input  logic [79:0]  s_axis_tdata,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], running[2], present_count[34:3], expiry_flags[39:35],
  // pretimer_event[40], expiry_event[43:41], log_state[44], use_state[47:45],
  // action_state[49:48], pretimer_state[52:50], pretimeout_state[84:53],
  // reload_state[116:85], zero pad[119:117]
  output logic [119:0] m_axis_tdata,
  // Watchdog number write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import wdt_pkg::*;

  logic         in_valid;
  wdt_item_t    in_item;
  logic         out_valid;
  wdt_result_t  out_result;
  wdt_result_t  core_result;
  logic         advance;
  logic         fire;
  logic [7:0]   watchdog_number;

  // The result register can take a new value when empty or being drained.
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.op                  <= wdt_op_t'(s_axis_tuser);
      in_item.log_enable          <= s_axis_tdata[0];
      in_item.timer_use           <= s_axis_tdata[3:1];
      in_item.timer_action        <= s_axis_tdata[5:4];
      in_item.pretimer_mode       <= s_axis_tdata[8:6];
      in_item.pretimeout_interval <= s_axis_tdata[40:9];
      in_item.initial_count       <= s_axis_tdata[72:41];
      in_item.clear_flags         <= s_axis_tdata[77:73];
      in_item.start_running       <= s_axis_tdata[78];
    end
  end

  wdt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0,
                          out_result.reload_state,
                          out_result.pretimeout_state,
                          out_result.pretimer_state,
                          out_result.action_state,
                          out_result.use_state,
                          out_result.log_state,
                          out_result.expiry_event,
                          out_result.pretimer_event,
                          out_result.expiry_flags,
                          out_result.present_count,
                          out_result.running,
                          out_result.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_number <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      watchdog_number <= cfg_data;
    end
  end

  `WDT_ASSERT(a_item_kept, clk, rst,
    in_valid && !advance |=> in_valid && $stable(in_item), "stalled item was lost")
  `WDT_ASSERT(a_number_hold, clk, rst,
    !(cfg_valid && cfg_ready) |=> $stable(watchdog_number), "watchdog number changed")
  `WDT_ASSERT_ALWAYS(a_reset_empty, clk,
    rst |=> !in_valid && !out_valid, "pipeline not empty after reset")

endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// Watchdog timer testbench
// Drives get, set, kick and tick operations into the watchdog stream port and
// checks every result transfer against a cycle-free model of the timer held
// in the bench. A short directed part covers reset values, rejected settings,
// refused kicks, pretimer and expiry events and count saturation. Random
// traffic with gaps and backpressure follows, between watchdog number writes.
// ---------------------------------------------------------------------------
module tb_top;
  import wdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 1000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser;   // op[1:0]
  // log_enable[0], timer_use[3:1], timer_action[5:4], pretimer_mode[8:6],
  // pretimeout_interval[40:9], initial_count[72:41], clear_flags[77:73],
  // start_running[78], zero pad[79]
  logic [79:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // status[1:0], running[2], present_count[34:3], expiry_flags[39:35],
  // pretimer_event[40], expiry_event[43:41], log_state[44], use_state[47:45],
  // action_state[49:48], pretimer_state[52:50], pretimeout_state[84:53],
  // reload_state[116:85], zero pad[119:117]
  logic [119:0] m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_data;

  watchdog_timer_with_pretimeout dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Predicted timer state, updated once per accepted operation.
  logic        wd_running;
  logic [31:0] wd_count;
  logic [4:0]  wd_flags;
  logic        wd_log;
  logic [2:0]  wd_use;
  logic [1:0]  wd_action;
  logic [2:0]  wd_pretimer;
  logic [31:0] wd_pretimeout;
  logic [31:0] wd_reload;
  // The watchdog number only travels to the event sink, so no result shows it.
  logic [7:0]  wd_number;

  // Results predicted for accepted operations, oldest first.
  wdt_result_t pending_results[$];
  int unsigned error_count;
  int unsigned hang_cycles;

  // Idling controls, switched per phase by the test tasks.
  bit          sender_gaps;
  bit          receiver_stalls;
  int unsigned stall_left;

  // -------------------------------------------------------------------------
  // Clock and reset.
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Timer model.
  // -------------------------------------------------------------------------

  // Compare step shared by a tick and by a kick with a zero reload. The
  // pretimer event needs an armed mode, logging on and the count sitting
  // exactly on the pretimeout; reaching zero stops the timer and latches the
  // use's flag whether or not logging is on.
  function automatic void compare_and_expire(inout wdt_result_t res);
    if (wd_pretimer != PRETIMER_NONE && wd_count == wd_pretimeout && wd_log) begin
      res.pretimer_event = 1'b1;
    end
    if (wd_count == 32'd0) begin
      if (wd_use >= 3'd1 && wd_use <= 3'd5) begin
        wd_flags = wd_flags | (5'b00001 << (wd_use - 3'd1));
      end
      wd_running = 1'b0;
      if (wd_log) begin
        res.expiry_event = {1'b0, wd_action} + 3'd1;
      end
    end
  endfunction

  function automatic wdt_result_t advance_watchdog(input wdt_item_t it);
    wdt_result_t res;
    res = '0;
    res.status = ST_OK;
    case (it.op)
      OP_SET: begin
        if (it.pretimeout_interval > it.initial_count) begin
          res.status = ST_BAD_DATA;
        end else begin
          wd_log        = it.log_enable;
          wd_use        = it.timer_use;
          wd_action     = it.timer_action;
          wd_pretimer   = it.pretimer_mode;
          wd_pretimeout = it.pretimeout_interval;
          wd_reload     = it.initial_count;
          wd_flags      = wd_flags & ~it.clear_flags;
          // A set never starts the timer; it can only stop it or reload it.
          if (!it.start_running) begin
            wd_running = 1'b0;
          end else begin
            wd_count = wd_reload;
          end
        end
      end
      OP_KICK: begin
        if (wd_running && wd_pretimer != PRETIMER_NONE && wd_count < wd_pretimeout) begin
          res.status = ST_BAD_REQ;
        end else begin
          wd_running = 1'b1;
          wd_count   = wd_reload;
          if (wd_reload == 32'd0) begin
            compare_and_expire(res);
          end
        end
      end
      OP_TICK: begin
        if (wd_running) begin
          // The count saturates at zero.
          if (wd_count != 32'd0) begin
            wd_count = wd_count - 32'd1;
          end
          compare_and_expire(res);
        end
      end
      default: begin
      end
    endcase
    res.running          = wd_running;
    res.present_count    = wd_count;
    res.expiry_flags     = wd_flags;
    res.log_state        = wd_log;
    res.use_state        = wd_use;
    res.action_state     = wd_action;
    res.pretimer_state   = wd_pretimer;
    res.pretimeout_state = wd_pretimeout;
    res.reload_state     = wd_reload;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one; none if disabled.
  function automatic int unsigned idle_length(input bit enabled);
    int unsigned roll;
    roll = $urandom_range(99);
    if (!enabled || roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic wdt_item_t plain_op(input wdt_op_t op);
    wdt_item_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  function automatic wdt_item_t set_op(input logic log_en, input logic [2:0] use_code,
                                       input logic [1:0] action, input logic [2:0] pre_mode,
                                       input logic [31:0] pretimeout, input logic [31:0] reload,
                                       input logic [4:0] clear, input logic start);
    wdt_item_t it;
    it = '0;
    it.op                  = OP_SET;
    it.log_enable          = log_en;
    it.timer_use           = use_code;
    it.timer_action        = action;
    it.pretimer_mode       = pre_mode;
    it.pretimeout_interval = pretimeout;
    it.initial_count       = reload;
    it.clear_flags         = clear;
    it.start_running       = start;
    return it;
  endfunction

  // Random operation. Ticks dominate and most settings use short counts so
  // that timers really run down to the pretimer and expiry points; a few
  // settings carry full-width values, about half of them rejected.
  function automatic wdt_item_t random_op();
    wdt_item_t   it;
    int unsigned roll;
    it.log_enable          = $urandom_range(1);
    it.timer_use           = $urandom_range(7);
    it.timer_action        = $urandom_range(3);
    it.pretimer_mode       = $urandom_range(7);
    it.pretimeout_interval = $urandom;
    it.initial_count       = $urandom;
    it.clear_flags         = $urandom_range(31);
    it.start_running       = $urandom_range(1);
    roll = $urandom_range(99);
    if (roll < 12) begin
      it.op = OP_GET;
    end else if (roll < 32) begin
      it.op = OP_SET;
      if ($urandom_range(9) != 0) begin
        it.initial_count       = $urandom_range(40);
        it.pretimeout_interval = $urandom_range(it.initial_count + 2);
        it.log_enable          = ($urandom_range(7) != 0);
        if ($urandom_range(3) != 0) begin
          it.pretimer_mode = $urandom_range(7, 1);
        end
      end
    end else if (roll < 47) begin
      it.op = OP_KICK;
    end else begin
      it.op = OP_TICK;
    end
    return it;
  endfunction

  // Presents one operation and holds it until the transfer. Entered and left
  // at a falling edge; tvalid stays high on return so that the next call can
  // follow back to back, and every other caller lowers it first.
  task automatic send_op(input wdt_item_t it);
    int unsigned gap;
    gap = idle_length(sender_gaps);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {1'b0, it.start_running, it.clear_flags, it.initial_count,
                      it.pretimeout_interval, it.pretimer_mode, it.timer_action,
                      it.timer_use, it.log_enable};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    pending_results.push_back(advance_watchdog(it));
    @(negedge clk);
  endtask

  // Stops sending, waits for every outstanding result and lets the pipeline
  // settle.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_watchdog_number(input logic [7:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    wd_number = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test tasks.
  // -------------------------------------------------------------------------

  // A get right after reset shows the reset settings and a stopped timer.
  task automatic test_reset_values();
    send_op(plain_op(OP_GET));
    wait_for_results();
  endtask

  // Pretimeout above the initial count is refused, also at the top of the
  // range; equal full-width values are accepted and count down normally.
  task automatic test_set_validation();
    send_op(set_op(1'b1, 3'd2, 2'd1, 3'd1, 32'd1, 32'd0, 5'd0, 1'b0));
    send_op(set_op(1'b0, 3'd3, 2'd2, 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 5'd0, 1'b1));
    send_op(set_op(1'b1, 3'd4, 2'd1, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F, 1'b1));
    send_op(plain_op(OP_KICK));
    send_op(plain_op(OP_TICK));
    send_op(plain_op(OP_GET));
    wait_for_results();
  endtask

  // Short countdown through the pretimer point, a kick refused below the
  // pretimeout, expiry at zero and a tick on the stopped timer.
  task automatic test_countdown_and_expiry();
    send_op(set_op(1'b1, 3'd1, 2'd3, 3'd2, 32'd2, 32'd3, 5'd0, 1'b1));
    send_op(plain_op(OP_KICK));
    send_op(plain_op(OP_TICK));
    send_op(plain_op(OP_TICK));
    send_op(plain_op(OP_KICK));
    send_op(plain_op(OP_TICK));
    send_op(plain_op(OP_TICK));
    send_op(plain_op(OP_GET));
    wait_for_results();
  endtask

  // A kick with a zero initial count expires at once. Covers logging off,
  // uses without a flag, out-of-range pretimer modes and clearing flags.
  task automatic test_zero_count_expiry();
    send_op(set_op(1'b1, 3'd5, 2'd0, 3'd1, 32'd0, 32'd0, 5'd0, 1'b0));
    send_op(plain_op(OP_KICK));
    send_op(set_op(1'b0, 3'd6, 2'd2, 3'd7, 32'd0, 32'd0, 5'd0, 1'b0));
    send_op(plain_op(OP_KICK));
    send_op(set_op(1'b1, 3'd7, 2'd1, 3'd0, 32'd0, 32'd0, 5'h1F, 1'b0));
    send_op(plain_op(OP_KICK));
    wait_for_results();
  endtask

  // A set that reloads a zero count leaves the timer running at zero; the
  // next tick must not wrap and expires instead.
  task automatic test_count_saturation();
    send_op(set_op(1'b1, 3'd3, 2'd2, 3'd5, 32'd10, 32'd50, 5'd0, 1'b0));
    send_op(plain_op(OP_KICK));
    send_op(set_op(1'b1, 3'd3, 2'd2, 3'd5, 32'd0, 32'd0, 5'd0, 1'b1));
    send_op(plain_op(OP_TICK));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit gaps,
                                     input bit stalls);
    sender_gaps     = gaps;
    receiver_stalls = stalls;
    repeat (count) send_op(random_op());
    wait_for_results();
  endtask

  // The sender stops now and then until the pipeline has fully drained.
  task automatic test_drain_pause(input int unsigned bursts);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b1;
    repeat (bursts) begin
      repeat ($urandom_range(40, 1)) send_op(random_op());
      wait_for_results();
    end
  endtask

  // -------------------------------------------------------------------------
  // Result checking: each result transfer is matched against the oldest
  // prediction.
  // -------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    wdt_result_t want;
    wdt_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[116:0];
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transfer with no operation outstanding, data %0h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("running", want.running, got.running);
        compare_field("present_count", want.present_count, got.present_count);
        compare_field("expiry_flags", want.expiry_flags, got.expiry_flags);
        compare_field("pretimer_event", want.pretimer_event, got.pretimer_event);
        compare_field("expiry_event", want.expiry_event, got.expiry_event);
        compare_field("log_state", want.log_state, got.log_state);
        compare_field("use_state", want.use_state, got.use_state);
        compare_field("action_state", want.action_state, got.action_state);
        compare_field("pretimer_state", want.pretimer_state, got.pretimer_state);
        compare_field("pretimeout_state", want.pretimeout_state, got.pretimeout_state);
        compare_field("reload_state", want.reload_state, got.reload_state);
      end
    end
  end

  // Receiver backpressure: random stalls, mostly short, a few long.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(99) < 25) begin
      stall_left    <= idle_length(1'b1);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Hang detection: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, hang_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence.
  // -------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tuser    = '0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b1;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    error_count     = 0;
    hang_cycles     = 0;
    stall_left      = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;

    // Model state after reset.
    wd_running    = 1'b0;
    wd_count      = 32'd0;
    wd_flags      = 5'd0;
    wd_log        = RST_LOG_ON;
    wd_use        = RST_USE_CODE;
    wd_action     = RST_ACTION_CODE;
    wd_pretimer   = RST_PRETIMER_CODE;
    wd_pretimeout = RST_PRETIMEOUT;
    wd_reload     = RST_RELOAD;
    wd_number     = 8'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    write_watchdog_number(8'hFF);
    test_set_validation();
    test_countdown_and_expiry();
    test_zero_count_expiry();
    test_count_saturation();

    // Full rate in both directions first, then idling on both sides, then on one.
    write_watchdog_number($urandom_range(254, 1));
    test_random_traffic(400, 1'b0, 1'b0);
    write_watchdog_number(8'h00);
    test_random_traffic(600, 1'b1, 1'b1);
    test_drain_pause(8);
    write_watchdog_number(8'hFF);
    test_random_traffic(300, 1'b1, 1'b0);
    write_watchdog_number($urandom_range(255));
    test_random_traffic(500, 1'b0, 1'b1);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
